/* hw/rtl/tri_adj_pkg.sv */
// Package for the triangle adjacency finder: default sizes, command and
// register codes, and the control/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package tri_adj_pkg;

  // Default sizes
  localparam int unsigned MaxCellsDef  = 1024;
  localparam int unsigned CoordBitsDef = 24;
  localparam int unsigned MaxLinks     = 3;

  // Fixed field widths
  localparam int unsigned IdxW    = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned DistW   = 24;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned LinkW   = 2;

  // Input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CELL_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MATCH_DIST = 1'd1;

  // Log2 of the cap on each coordinate difference
  localparam int unsigned DiffCapLog = 24;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_we;    // write the input triangle into the store
    logic clear;      // clear the link list for a new transaction
    logic self_cap;   // capture the queried triangle from the read port
    logic scan_valid; // the row read this cycle is a candidate
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;       // candidates still in the compare pipeline
    logic last;       // the result shown now is the final one
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/triangle_adjacency_finder.sv */
// Top level of the triangle adjacency finder: controller plus datapath.
// Depends on tri_adj_pkg, tri_adj_ctrl and tri_adj_dp.
//
// Usage: an input transaction (in_valid_i/in_ready_o) either loads a
// triangle into slot cell_index_i (cmd_i = 0) or queries the neighbours of
// that slot (cmd_i = 1). Results leave on out_valid_o/out_ready_i, last_o
// marking the final one of each transaction. A load gives one acknowledge in
// the cycle after acceptance. A query of a slot below limit reads its own
// triangle (SELF_RD, SELF_CAP), then streams each stored triangle below
// limit, one per cycle, from the store's read port through a 4-stage
// compare pipeline and emits once it drains, limit being cell_count
// saturated at MAX_CELLS. One transaction is handled at a time; in_ready_o
// is high only while idle. Results are held stable while the receiver
// stalls. Reset clears control state and sets cell_count 0 and match_dist_sq
// 105; the triangle store is undefined until loaded. Configuration writes
// (cfg_we_i) take effect at once and must be done while idle (not enforced).
`default_nettype none

module triangle_adjacency_finder #(
  parameter int unsigned MAX_CELLS  = tri_adj_pkg::MaxCellsDef,
  parameter int unsigned COORD_BITS = tri_adj_pkg::CoordBitsDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              cmd_i,
  input  wire  [tri_adj_pkg::IdxW-1:0]     cell_index_i,
  input  wire  signed [COORD_BITS-1:0]     ax_i,
  input  wire  signed [COORD_BITS-1:0]     ay_i,
  input  wire  signed [COORD_BITS-1:0]     az_i,
  input  wire  signed [COORD_BITS-1:0]     bx_i,
  input  wire  signed [COORD_BITS-1:0]     by_i,
  input  wire  signed [COORD_BITS-1:0]     bz_i,
  input  wire  signed [COORD_BITS-1:0]     cx_i,
  input  wire  signed [COORD_BITS-1:0]     cy_i,
  input  wire  signed [COORD_BITS-1:0]     cz_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             found_o,
  output logic [tri_adj_pkg::IdxW-1:0]     neighbour_index_o,
  output logic [tri_adj_pkg::LinkW-1:0]    link_slot_o,
  output logic                             overflow_o,
  output logic                             last_o,
  input  wire                              cfg_we_i,
  input  wire  [tri_adj_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [tri_adj_pkg::DistW-1:0]    cfg_data_i
);

  tri_adj_pkg::ctl_cmd_t             cmd;
  tri_adj_pkg::dp_stat_t             stat;
  logic [$clog2(MAX_CELLS)-1:0]      rd_addr;
  logic [tri_adj_pkg::LinkW-1:0]     emit_sel;
  logic [9*COORD_BITS-1:0]           tri_row;

  // Pack vertices, vertex 0 x in the low bits
  assign tri_row = {cz_i, cy_i, cx_i, bz_i, by_i, bx_i, az_i, ay_i, ax_i};

  tri_adj_ctrl #(
    .MAX_CELLS (MAX_CELLS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .cell_index_i (cell_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_o        (cmd),
    .rd_addr_o    (rd_addr),
    .emit_sel_o   (emit_sel),
    .stat_i       (stat)
  );

  tri_adj_dp #(
    .MAX_CELLS  (MAX_CELLS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .rd_addr_i         (rd_addr),
    .emit_sel_i        (emit_sel),
    .stat_o            (stat),
    .cell_index_i      (cell_index_i),
    .tri_i             (tri_row),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .found_o           (found_o),
    .neighbour_index_o (neighbour_index_o),
    .link_slot_o       (link_slot_o),
    .overflow_o        (overflow_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/tri_adj_ctrl.sv */
// Controller for the triangle adjacency finder: handshakes, scan counter,
// configuration of the count register. Depends on tri_adj_pkg.
`default_nettype none

module tri_adj_ctrl #(
  parameter int unsigned MAX_CELLS = tri_adj_pkg::MaxCellsDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire                                cmd_i,
  input  wire  [tri_adj_pkg::IdxW-1:0]       cell_index_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  input  wire                                cfg_we_i,
  input  wire  [tri_adj_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [tri_adj_pkg::DistW-1:0]      cfg_data_i,
  output tri_adj_pkg::ctl_cmd_t              cmd_o,
  output logic [$clog2(MAX_CELLS)-1:0]       rd_addr_o,
  output logic [tri_adj_pkg::LinkW-1:0]      emit_sel_o,
  input  tri_adj_pkg::dp_stat_t              stat_i
);

  localparam int unsigned AddrW = $clog2(MAX_CELLS);
  localparam int unsigned LimW  = $clog2(MAX_CELLS + 1);
  localparam int unsigned CW    = (LimW > tri_adj_pkg::CountW) ? LimW : tri_adj_pkg::CountW;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SELF_RD  = 3'd1;
  localparam logic [2:0] ST_SELF_CAP = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_DRAIN    = 3'd4;
  localparam logic [2:0] ST_EMIT     = 3'd5;

  logic [2:0]                       state_q, state_d;
  logic [CW-1:0]                    slot_q, slot_d;
  logic [LimW-1:0]                  scan_q, scan_d;
  logic [tri_adj_pkg::LinkW-1:0]    emit_q, emit_d;
  logic [tri_adj_pkg::CountW-1:0]   count_q;
  logic [CW-1:0]                    limit;
  logic [CW-1:0]                    count_ext;
  logic [CW-1:0]                    in_slot;

  // Saturate the count at the store depth
  assign count_ext = CW'(count_q);
  assign limit     = (count_ext > CW'(MAX_CELLS)) ? CW'(MAX_CELLS) : count_ext;
  assign in_slot   = CW'(cell_index_i);

  // Count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == tri_adj_pkg::CFG_CELL_COUNT)) begin
      count_q <= cfg_data_i[tri_adj_pkg::CountW-1:0];
    end
  end

  // Sequence one transaction at a time
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    scan_d      = scan_q;
    emit_d      = emit_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    rd_addr_o   = scan_q[AddrW-1:0];
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.clear = 1'b1;
          emit_d      = '0;
          slot_d      = in_slot;
          if (cmd_i == tri_adj_pkg::CMD_LOAD) begin
            cmd_o.load_we = (in_slot < CW'(MAX_CELLS));
            state_d       = ST_EMIT;
          end else if (in_slot < limit) begin
            state_d = ST_SELF_RD;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SELF_RD: begin
        rd_addr_o = slot_q[AddrW-1:0];
        state_d   = ST_SELF_CAP;
      end
      ST_SELF_CAP: begin
        cmd_o.self_cap = 1'b1;
        scan_d         = '0;
        state_d        = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_valid = (CW'(scan_q) != slot_q);
        scan_d           = scan_q + LimW'(1);
        if ((CW'(scan_q) + CW'(1)) == limit) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.last) begin
            state_d = ST_IDLE;
          end else begin
            emit_d = emit_q + tri_adj_pkg::LinkW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign emit_sel_o = emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    scan_q <= scan_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/tri_adj_dp.sv */
// Datapath for the triangle adjacency finder: triangle store, compare
// pipeline, link list and result fields. Depends on tri_adj_pkg.
`default_nettype none

module tri_adj_dp #(
  parameter int unsigned MAX_CELLS  = tri_adj_pkg::MaxCellsDef,
  parameter int unsigned COORD_BITS = tri_adj_pkg::CoordBitsDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  tri_adj_pkg::ctl_cmd_t              cmd_i,
  input  wire  [$clog2(MAX_CELLS)-1:0]       rd_addr_i,
  input  wire  [tri_adj_pkg::LinkW-1:0]      emit_sel_i,
  output tri_adj_pkg::dp_stat_t              stat_o,
  input  wire  [tri_adj_pkg::IdxW-1:0]       cell_index_i,
  input  wire  [9*COORD_BITS-1:0]            tri_i,
  input  wire                                cfg_we_i,
  input  wire  [tri_adj_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [tri_adj_pkg::DistW-1:0]      cfg_data_i,
  output logic                               found_o,
  output logic [tri_adj_pkg::IdxW-1:0]       neighbour_index_o,
  output logic [tri_adj_pkg::LinkW-1:0]      link_slot_o,
  output logic                               overflow_o,
  output logic                               last_o
);

  localparam int unsigned AddrW = $clog2(MAX_CELLS);
  localparam int unsigned LimW  = $clog2(MAX_CELLS + 1);
  localparam int unsigned CW    = (LimW > tri_adj_pkg::CountW) ? LimW : tri_adj_pkg::CountW;
  localparam int unsigned RowW  = 9 * COORD_BITS;
  localparam int unsigned CapLim = tri_adj_pkg::DiffCapLog + 1;
  localparam int unsigned ExtW  = (COORD_BITS > CapLim) ? COORD_BITS : CapLim;
  localparam int unsigned CapW  = (COORD_BITS > tri_adj_pkg::DiffCapLog) ? CapLim : COORD_BITS;
  localparam int unsigned SqW   = 2 * CapW;
  localparam int unsigned SumW  = SqW + 2;
  localparam int unsigned CmpW  = (SumW > tri_adj_pkg::DistW) ? SumW : tri_adj_pkg::DistW;
  localparam logic [ExtW-1:0] DiffCap = ExtW'(1) << tri_adj_pkg::DiffCapLog;
  localparam logic [COORD_BITS-1:0] SignBit = COORD_BITS'(1) << (COORD_BITS - 1);

  logic [RowW-1:0]               mem [MAX_CELLS];
  logic [RowW-1:0]               rd_data_q;
  logic [RowW-1:0]               self_q;
  logic [RowW-1:0]               wr_row;
  logic [AddrW-1:0]              wr_addr;
  logic [CW-1:0]                 wr_ext;
  logic [tri_adj_pkg::DistW-1:0] dist_q;

  logic                          v1_q, v2_q, v3_q, v4_q;
  logic [AddrW-1:0]              idx1_q, idx2_q, idx3_q, idx4_q;
  logic [CapW-1:0]               diff_q [27];
  logic [SqW-1:0]                sq_q [27];
  logic [8:0]                    match_q;

  logic [1:0]                    n_q;
  logic                          ovf_q;
  logic [AddrW-1:0]              link_q [tri_adj_pkg::MaxLinks];
  logic [3:0]                    hits;
  logic [AddrW+tri_adj_pkg::IdxW-1:0] idx_wide;
  logic [AddrW-1:0]              sel_idx;

  // Match distance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= tri_adj_pkg::DistW'(105);
    end else if (cfg_we_i && (cfg_idx_i == tri_adj_pkg::CFG_MATCH_DIST)) begin
      dist_q <= cfg_data_i;
    end
  end

  // Flip sign bits so that unsigned order follows signed order
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      wr_row[k*COORD_BITS +: COORD_BITS] = tri_i[k*COORD_BITS +: COORD_BITS] ^ SignBit;
    end
  end

  assign wr_ext  = CW'(cell_index_i);
  assign wr_addr = wr_ext[AddrW-1:0];

  // Triangle store, one row per slot, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      mem[wr_addr] <= wr_row;
    end
    rd_data_q <= mem[rd_addr_i];
    if (cmd_i.self_cap) begin
      self_q <= rd_data_q;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.scan_valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Compare pipeline: difference, square, sum and threshold
  always_ff @(posedge clk_i) begin
    logic [COORD_BITS-1:0] a, b, d;
    logic [ExtW-1:0]       e;
    logic [SumW-1:0]       s;
    idx1_q <= rd_addr_i;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          a = self_q[(i*3+c)*COORD_BITS +: COORD_BITS];
          b = rd_data_q[(j*3+c)*COORD_BITS +: COORD_BITS];
          d = (a > b) ? (a - b) : (b - a);
          e = ExtW'(d);
          if (e > DiffCap) begin
            e = DiffCap;
          end
          diff_q[(i*3+j)*3+c] <= e[CapW-1:0];
          sq_q[(i*3+j)*3+c]   <= SqW'(diff_q[(i*3+j)*3+c]) * SqW'(diff_q[(i*3+j)*3+c]);
        end
        s = SumW'(sq_q[(i*3+j)*3]) + SumW'(sq_q[(i*3+j)*3+1]) + SumW'(sq_q[(i*3+j)*3+2]);
        match_q[i*3+j] <= (CmpW'(s) <= CmpW'(dist_q));
      end
    end
  end

  // Count matching vertex pairs
  always_comb begin
    hits = '0;
    for (int k = 0; k < 9; k++) begin
      hits = hits + 4'(match_q[k]);
    end
  end

  // Collect links in scan order, flag extras
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.clear) begin
      n_q   <= '0;
      ovf_q <= 1'b0;
    end else if (v4_q && (hits == 4'd2)) begin
      if (n_q < 2'(tri_adj_pkg::MaxLinks)) begin
        n_q <= n_q + 2'd1;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q && (hits == 4'd2) && (n_q < 2'(tri_adj_pkg::MaxLinks))) begin
      link_q[n_q] <= idx4_q;
    end
  end

  // Result fields
  always_comb begin
    case (emit_sel_i)
      2'd0:    sel_idx = link_q[0];
      2'd1:    sel_idx = link_q[1];
      default: sel_idx = link_q[2];
    endcase
  end

  assign found_o  = (n_q != 2'd0);
  assign idx_wide = {{tri_adj_pkg::IdxW{1'b0}}, sel_idx};
  assign neighbour_index_o = found_o ? idx_wide[tri_adj_pkg::IdxW-1:0] : '0;
  assign link_slot_o = found_o ? emit_sel_i : '0;
  assign overflow_o  = ovf_q;
  assign last_o      = !found_o || (emit_sel_i == (n_q - 2'd1));

  assign stat_o.busy = v1_q || v2_q || v3_q || v4_q;
  assign stat_o.last = last_o;

endmodule

`default_nettype wire

/* verif/tb_triangle_adjacency_finder.sv */
// Self-checking testbench for triangle_adjacency_finder: loads and queries
// triangles, predicts neighbour lists and checks every result transaction.
// Depends on tri_adj_pkg and the triangle_adjacency_finder RTL.
`default_nettype none

module tb_triangle_adjacency_finder;

  localparam int unsigned Cells = tri_adj_pkg::MaxCellsDef;
  localparam int unsigned QuietLimit = 20000;

  typedef struct packed {
    logic                          cmd;
    logic [tri_adj_pkg::IdxW-1:0]  idx;
    logic [8:0][23:0]              crd;
  } tri_item_t;

  typedef struct packed {
    logic                          found;
    logic [tri_adj_pkg::IdxW-1:0]  nidx;
    logic [tri_adj_pkg::LinkW-1:0] lslot;
    logic                          ovf;
    logic                          last;
  } adj_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found, ovf, last;
  logic [tri_adj_pkg::IdxW-1:0] nidx;
  logic [tri_adj_pkg::LinkW-1:0] lslot;
  logic cfg_we = 1'b0;
  logic [tri_adj_pkg::CfgIdxW-1:0] cfg_idx = tri_adj_pkg::CFG_CELL_COUNT;
  logic [tri_adj_pkg::DistW-1:0] cfg_data = '0;
  tri_item_t drv_item = '0;
  logic in_took = 1'b0;
  logic no_idle = 1'b0;
  bit failed = 1'b0;

  tri_item_t pending_items[$];
  adj_result_t results_due[$];

  // Predictor state
  logic signed [23:0] tri_store[Cells][9];
  int unsigned cell_count_q = 0;
  int unsigned match_dist_q = 105;
  logic signed [23:0] pool[8][3];

  always #10 clk_i = ~clk_i;

  triangle_adjacency_finder u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(drv_item.cmd), .cell_index_i(drv_item.idx),
    .ax_i(drv_item.crd[0]), .ay_i(drv_item.crd[1]), .az_i(drv_item.crd[2]),
    .bx_i(drv_item.crd[3]), .by_i(drv_item.crd[4]), .bz_i(drv_item.crd[5]),
    .cx_i(drv_item.crd[6]), .cy_i(drv_item.crd[7]), .cz_i(drv_item.crd[8]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .found_o(found), .neighbour_index_o(nidx), .link_slot_o(lslot),
    .overflow_o(ovf), .last_o(last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // Count vertex pairs of two slots within the match distance
  function automatic int unsigned shared_pairs(int p, int q);
    longint signed d;
    longint unsigned s;
    int unsigned n;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s = 0;
        for (int k = 0; k < 3; k++) begin
          d = longint'(tri_store[p][i*3+k]) - longint'(tri_store[q][j*3+k]);
          if (d < 0) d = -d;
          if (d > (64'sd1 << 24)) d = 64'sd1 << 24;
          s += longint'(d * d);
        end
        if (s <= longint'(match_dist_q)) n++;
      end
    end
    return n;
  endfunction

  // Update the store and queue the results one transaction causes
  task automatic predict_neighbours(tri_item_t it);
    int unsigned limit;
    int links[$];
    logic of;
    adj_result_t r;
    of = 1'b0;
    r = '{1'b0, '0, '0, 1'b0, 1'b1};
    if (it.cmd == tri_adj_pkg::CMD_LOAD) begin
      for (int k = 0; k < 9; k++) tri_store[it.idx][k] = it.crd[k];
      results_due = {results_due, r};
    end else begin
      limit = (cell_count_q > Cells) ? Cells : cell_count_q;
      if (it.idx < limit) begin
        for (int j = 0; j < int'(limit); j++) begin
          if (j != int'(it.idx) && shared_pairs(it.idx, j) == 2) begin
            if (links.size() < tri_adj_pkg::MaxLinks) links = {links, j};
            else of = 1'b1;
          end
        end
      end
      if (links.size() == 0) begin
        results_due = {results_due, r};
      end else begin
        foreach (links[k]) begin
          r = '{1'b1, tri_adj_pkg::IdxW'(links[k]), tri_adj_pkg::LinkW'(k), of,
                k == links.size() - 1};
          results_due = {results_due, r};
        end
      end
    end
  endtask

  // Accept transactions, check results, run the watchdog
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    adj_result_t e;
    in_took <= in_valid && in_ready;
    if (in_valid && in_ready) predict_neighbours(drv_item);
    if (out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result with no expectation waiting");
        failed = 1'b1;
      end else begin
        e = results_due.pop_front();
        if (found !== e.found) begin
          $error("found exp %0d got %0d", e.found, found); failed = 1'b1;
        end
        if (nidx !== e.nidx) begin
          $error("neighbour_index exp %0d got %0d", e.nidx, nidx); failed = 1'b1;
        end
        if (lslot !== e.lslot) begin
          $error("link_slot exp %0d got %0d", e.lslot, lslot); failed = 1'b1;
        end
        if (ovf !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, ovf); failed = 1'b1;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); failed = 1'b1;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("triangle_adjacency_finder regression: fail");
      $finish;
    end
  end

  // Drive input transactions from the pending queue with idle bursts
  int gap = 0;
  always @(negedge clk_i) begin
    logic nv;
    if (rst_ni && (!in_valid || in_took)) begin
      nv = 1'b0;
      if (gap > 0) begin
        gap--;
      end else if (pending_items.size() > 0) begin
        drv_item <= pending_items.pop_front();
        nv = 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
      end
      in_valid <= nv;
    end
  end

  // Stall the result channel in bursts
  int stall = 0;
  always @(negedge clk_i) begin
    if (stall > 0) begin
      stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 12);
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || results_due.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tri_adj_pkg::CfgIdxW-1:0] ri, int unsigned val);
    wait_idle();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= ri;
    cfg_data <= tri_adj_pkg::DistW'(val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (ri == tri_adj_pkg::CFG_CELL_COUNT) cell_count_q = val & 32'h7ff;
    else match_dist_q = val & 32'hffffff;
  endtask

  task automatic push_load(int unsigned slot, logic [8:0][23:0] c);
    tri_item_t it;
    it = '{tri_adj_pkg::CMD_LOAD, tri_adj_pkg::IdxW'(slot), c};
    pending_items = {pending_items, it};
  endtask

  task automatic push_query(int unsigned slot);
    tri_item_t it;
    it = '{tri_adj_pkg::CMD_QUERY, tri_adj_pkg::IdxW'(slot), '0};
    for (int k = 0; k < 9; k++) it.crd[k] = 24'($urandom);
    pending_items = {pending_items, it};
  endtask

  // Triangle from three pool points plus a jitter of up to jit per axis
  function automatic logic [8:0][23:0] pool_tri(int a, int b, int c, int jit);
    logic [8:0][23:0] t;
    int p[3];
    p = '{a, b, c};
    for (int v = 0; v < 3; v++)
      for (int k = 0; k < 3; k++)
        t[v*3+k] = pool[p[v]][k] + 24'($urandom_range(0, 2*jit)) - 24'(jit);
    return t;
  endfunction

  function automatic logic [8:0][23:0] rand_tri();
    logic [8:0][23:0] t;
    int a, b, c;
    if ($urandom_range(0, 7) == 0) begin
      for (int k = 0; k < 9; k++) t[k] = 24'($urandom);
      return t;
    end
    a = $urandom_range(0, 7);
    b = (a + $urandom_range(1, 7)) % 8;
    c = $urandom_range(0, 7);
    return pool_tri(a, b, c, ($urandom_range(0, 5) == 0) ? 40 : 4);
  endfunction

  task automatic new_pool();
    for (int i = 0; i < 8; i++)
      for (int k = 0; k < 3; k++) pool[i][k] = 24'($urandom);
  endtask

  task automatic random_phase(int unsigned cnt, int unsigned thr, int n);
    int unsigned lim;
    write_reg(tri_adj_pkg::CFG_MATCH_DIST, thr);
    write_reg(tri_adj_pkg::CFG_CELL_COUNT, cnt);
    lim = (cnt > Cells) ? Cells : cnt;
    new_pool();
    for (int s = 0; s < int'(lim); s++) push_load(s, rand_tri());
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: push_load($urandom_range(0, lim - 1), rand_tri());
        3:       push_load($urandom_range(lim, Cells - 1), rand_tri());
        4:       push_query($urandom_range(lim, Cells - 1));
        default: push_query($urandom_range(0, lim - 1));
      endcase
    end
  endtask

  initial begin
    logic [8:0][23:0] t;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme vertices, one shared edge, too many neighbours
    pool[0] = '{-24'sd8388608, 24'sd8388607, 24'sd0};
    pool[1] = '{24'sd8388607, -24'sd8388608, 24'sd8388607};
    pool[2] = '{24'sd0, 24'sd0, -24'sd8388608};
    for (int i = 3; i < 8; i++)
      for (int k = 0; k < 3; k++) pool[i][k] = 24'($urandom);
    push_query(0);                         // empty table, slot not below count
    push_load(0, pool_tri(0, 1, 2, 0));
    push_load(1, pool_tri(0, 1, 3, 3));    // shared edge
    push_load(2, pool_tri(1, 2, 4, 0));
    push_load(3, pool_tri(0, 2, 5, 0));
    push_load(4, pool_tri(0, 1, 6, 0));    // fourth neighbour of slot 0
    push_load(5, pool_tri(0, 1, 2, 0));    // three shared, not adjacent
    push_load(6, pool_tri(5, 6, 7, 0));    // isolated
    for (int k = 0; k < 9; k++) t[k] = (k % 2) ? 24'h7fffff : 24'h800000;
    push_load(Cells - 1, t);
    write_reg(tri_adj_pkg::CFG_CELL_COUNT, 7);
    for (int s = 0; s < 8; s++) push_query(s);
    push_query(Cells - 1);
    write_reg(tri_adj_pkg::CFG_MATCH_DIST, 0);
    push_query(1);

    // Random: several settings including the threshold extremes
    random_phase(16, 105, 70);
    random_phase(12, 0, 40);
    random_phase(20, 24'hffffff, 50);
    random_phase(16, 3000, 60);

    // Last part without idling on either side
    wait_idle();
    no_idle = 1'b1;
    random_phase(2, 105, 30);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("triangle_adjacency_finder regression: pass");
    end else begin
      $display("triangle_adjacency_finder regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/tri_adj_pkg.sv
hw/rtl/tri_adj_ctrl.sv
hw/rtl/tri_adj_dp.sv
hw/rtl/triangle_adjacency_finder.sv
verif/tb_triangle_adjacency_finder.sv
